>>> rtl/drt_pkg.sv
// drt_pkg: shared types, codes and helpers of the dirty rectangle tracker.
// No dependencies.
package drt_pkg;

  localparam int RECT_SLOTS_DEF = 16;
  localparam int CW             = 20;  // internal signed coordinate width
  localparam int AREA_W         = 16;
  localparam int CANVAS_W       = 15;
  localparam int OUT_W          = 15;
  localparam int IDX_OUT_W      = 4;
  localparam int CFG_IDX_W      = 2;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_LIST     = 2'd2;

  localparam logic [CANVAS_W-1:0] CANVAS_RESET = 15'd1024;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] w;
    logic signed [CW-1:0] h;
  } rect_t;

  localparam int RECT_BITS = $bits(rect_t);

  typedef struct packed {
    logic load_in;
    logic clear;
    logic box_add;
    logic box_clamp;
    logic idx_clr;
    logic idx_inc;
    logic merge_wr;
    logic append_wr;
    logic clamp_wr;
    logic poison_set;
    logic list_drop;
    logic count_zero;
    logic out_box;
    logic out_rect;
    logic out_last;
  } drt_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic area_ok;
    logic box_valid;
    logic poisoned;
    logic keep;
    logic list_empty;
    logic full;
    logic at_end;
    logic overlap;
    logic clamp_ok;
    logic last_rect;
    logic out_last;
  } drt_sts_t;

  // Clip a rectangle to the canvas, left/top first, then right/bottom.
  function automatic rect_t clamp_rect(input rect_t r, input logic signed [CW-1:0] cw,
                                       input logic signed [CW-1:0] ch);
    rect_t c;
    c = r;
    if (c.x < 0) begin
      c.w = c.w + c.x;
      c.x = '0;
    end
    if (c.y < 0) begin
      c.h = c.h + c.y;
      c.y = '0;
    end
    if (c.x + c.w > cw) c.w = cw - c.x;
    if (c.y + c.h > ch) c.h = ch - c.y;
    return c;
  endfunction

endpackage

>>> rtl/drt_in_if.sv
// drt_in_if: request channel carrying one tracker command.
// Depends on drt_pkg for field widths.
interface drt_in_if import drt_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [1:0]               op;
  logic signed [AREA_W-1:0] area_x;
  logic signed [AREA_W-1:0] area_y;
  logic signed [AREA_W-1:0] area_w;
  logic signed [AREA_W-1:0] area_h;

  modport source (output valid, op, area_x, area_y, area_w, area_h, input ready);
  modport sink   (input valid, op, area_x, area_y, area_w, area_h, output ready);
endinterface

>>> rtl/drt_out_if.sv
// drt_out_if: result channel carrying one box or rectangle.
// Depends on drt_pkg for field widths.
interface drt_out_if import drt_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic                 present;
  logic [OUT_W-1:0]     out_x;
  logic [OUT_W-1:0]     out_y;
  logic [OUT_W-1:0]     out_w;
  logic [OUT_W-1:0]     out_h;
  logic [IDX_OUT_W-1:0] rect_index;
  logic                 last;

  modport source (output valid, kind, present, out_x, out_y, out_w, out_h, rect_index, last,
                  input ready);
  modport sink   (input valid, kind, present, out_x, out_y, out_w, out_h, rect_index, last,
                  output ready);
endinterface

>>> rtl/drt_ram.sv
// drt_ram: generic single write, single registered read port RAM.
// No dependencies.
module drt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/drt_ctrl.sv
// drt_ctrl: sequencer of the dirty rectangle tracker.
// Depends on drt_pkg; drives drt_dp through command/status structs.
module drt_ctrl import drt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  drt_sts_t sts,
  output drt_cmd_t cmd
);
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DEC      = 4'd1;
  localparam logic [3:0] S_SCAN_RD  = 4'd2;
  localparam logic [3:0] S_SCAN_CHK = 4'd3;
  localparam logic [3:0] S_FIN_CHK  = 4'd4;
  localparam logic [3:0] S_CL_RD    = 4'd5;
  localparam logic [3:0] S_CL_CHK   = 4'd6;
  localparam logic [3:0] S_OUT_BOX  = 4'd7;
  localparam logic [3:0] S_EM_RD    = 4'd8;
  localparam logic [3:0] S_EM_LD    = 4'd9;
  localparam logic [3:0] S_OUT_RECT = 4'd10;

  logic [3:0] state, state_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT_BOX) || (state == S_OUT_RECT);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DEC;
        end
      end
      S_DEC: begin
        state_next = S_IDLE;
        case (sts.op)
          OP_CLEAR: cmd.clear = 1'b1;
          OP_ADD: begin
            if (sts.area_ok) begin
              cmd.box_add = 1'b1;
              if (!sts.poisoned) begin
                cmd.idx_clr = 1'b1;
                state_next  = S_SCAN_RD;
              end
            end
          end
          OP_FINISH: begin
            if (!sts.box_valid) begin
              cmd.out_box  = 1'b1;
              cmd.out_last = 1'b1;
              state_next   = S_OUT_BOX;
            end else begin
              cmd.box_clamp = 1'b1;
              state_next    = S_FIN_CHK;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_SCAN_RD: begin
        if (sts.at_end) begin
          if (sts.full) cmd.poison_set = 1'b1;
          else cmd.append_wr = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (sts.overlap) begin
          cmd.merge_wr = 1'b1;
          state_next   = S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SCAN_RD;
        end
      end
      S_FIN_CHK: begin
        if (!sts.box_valid || sts.poisoned || sts.list_empty || !sts.keep) begin
          cmd.list_drop = 1'b1;
          cmd.out_box   = 1'b1;
          cmd.out_last  = 1'b1;
          state_next    = S_OUT_BOX;
        end else begin
          cmd.idx_clr = 1'b1;
          state_next  = S_CL_RD;
        end
      end
      S_CL_RD: begin
        if (sts.at_end) begin
          cmd.out_box = 1'b1;
          cmd.idx_clr = 1'b1;
          state_next  = S_OUT_BOX;
        end else begin
          state_next = S_CL_CHK;
        end
      end
      S_CL_CHK: begin
        cmd.clamp_wr = 1'b1;
        if (!sts.clamp_ok) begin
          cmd.count_zero = 1'b1;
          cmd.out_box    = 1'b1;
          cmd.out_last   = 1'b1;
          state_next     = S_OUT_BOX;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_CL_RD;
        end
      end
      S_OUT_BOX: begin
        if (out_ready) state_next = sts.out_last ? S_IDLE : S_EM_RD;
      end
      S_EM_RD: state_next = S_EM_LD;
      S_EM_LD: begin
        cmd.out_rect = 1'b1;
        cmd.out_last = sts.last_rect;
        state_next   = S_OUT_RECT;
      end
      S_OUT_RECT: begin
        if (out_ready) begin
          if (sts.out_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_EM_RD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule

>>> rtl/drt_dp.sv
// drt_dp: box registers, rectangle list storage, clamp and merge arithmetic.
// Depends on drt_pkg and drt_ram.
module drt_dp import drt_pkg::*; #(
  parameter int RECT_SLOTS = RECT_SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  drt_cmd_t                 cmd,
  output drt_sts_t                 sts,
  input  logic [1:0]               in_op,
  input  logic signed [AREA_W-1:0] in_x,
  input  logic signed [AREA_W-1:0] in_y,
  input  logic signed [AREA_W-1:0] in_w,
  input  logic signed [AREA_W-1:0] in_h,
  input  logic [CANVAS_W-1:0]      canvas_width,
  input  logic [CANVAS_W-1:0]      canvas_height,
  input  logic                     keep_list,
  output logic                     res_kind,
  output logic                     res_present,
  output logic [OUT_W-1:0]         res_x,
  output logic [OUT_W-1:0]         res_y,
  output logic [OUT_W-1:0]         res_w,
  output logic [OUT_W-1:0]         res_h,
  output logic [IDX_OUT_W-1:0]     res_index,
  output logic                     res_last
);
  localparam int AW   = (RECT_SLOTS > 1) ? $clog2(RECT_SLOTS) : 1;
  localparam int CNTW = $clog2(RECT_SLOTS + 1);

  logic [1:0]    op;
  rect_t         area;
  rect_t         box;
  logic          box_valid;
  logic [CNTW-1:0] count, idx;
  logic          poisoned;

  logic signed [CW-1:0] cw_s, ch_s;
  rect_t         rd, merged, rd_clamped, box_union, box_clamped, wr_data;
  logic signed [CW-1:0] ax1, ay1, rx1, ry1, bx1, by1, ux1, uy1;
  logic          box_keep, we;
  logic [AW-1:0] waddr;

  assign cw_s = signed'({{(CW-CANVAS_W){1'b0}}, canvas_width});
  assign ch_s = signed'({{(CW-CANVAS_W){1'b0}}, canvas_height});

  // Bounding box growth.
  assign ax1 = area.x + area.w;
  assign ay1 = area.y + area.h;
  assign bx1 = box.x + box.w;
  assign by1 = box.y + box.h;
  always_comb begin
    box_union   = box;
    box_union.x = (area.x < box.x) ? area.x : box.x;
    box_union.y = (area.y < box.y) ? area.y : box.y;
    ux1         = (ax1 > bx1) ? ax1 : bx1;
    uy1         = (ay1 > by1) ? ay1 : by1;
    box_union.w = ux1 - box_union.x;
    box_union.h = uy1 - box_union.y;
  end

  assign box_clamped = clamp_rect(box, cw_s, ch_s);
  assign box_keep    = (box_clamped.w > 0) && (box_clamped.h > 0) &&
                       !((box_clamped.w >= cw_s) && (box_clamped.h >= ch_s));

  // Stored rectangle: overlap, merge and clamp.
  assign rx1 = rd.x + rd.w;
  assign ry1 = rd.y + rd.h;
  always_comb begin
    merged   = rd;
    merged.x = (area.x < rd.x) ? area.x : rd.x;
    merged.y = (area.y < rd.y) ? area.y : rd.y;
    merged.w = ((ax1 > rx1) ? ax1 : rx1) - merged.x;
    merged.h = ((ay1 > ry1) ? ay1 : ry1) - merged.y;
  end
  assign rd_clamped = clamp_rect(rd, cw_s, ch_s);

  assign we      = cmd.merge_wr || cmd.append_wr || cmd.clamp_wr;
  assign waddr   = cmd.append_wr ? count[AW-1:0] : idx[AW-1:0];
  assign wr_data = cmd.append_wr ? area : (cmd.merge_wr ? merged : rd_clamped);

  drt_ram #(.WIDTH(RECT_BITS), .DEPTH(RECT_SLOTS), .AW(AW)) u_list (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wr_data),
    .raddr (idx[AW-1:0]),
    .rdata (rd)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op     <= in_op;
      area.x <= CW'(in_x);
      area.y <= CW'(in_y);
      area.w <= CW'(in_w);
      area.h <= CW'(in_h);
    end
    if (cmd.box_add) box <= box_valid ? box_union : area;
    else if (cmd.box_clamp) box <= box_clamped;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      box_valid <= 1'b0;
      count     <= '0;
      poisoned  <= 1'b0;
      idx       <= '0;
    end else begin
      if (cmd.clear) begin
        box_valid <= 1'b0;
        count     <= '0;
        poisoned  <= 1'b0;
      end
      if (cmd.box_add) box_valid <= 1'b1;
      if (cmd.box_clamp) box_valid <= box_keep;
      if (cmd.append_wr) count <= count + CNTW'(1);
      if (cmd.poison_set) poisoned <= 1'b1;
      if (cmd.list_drop) begin
        count    <= '0;
        poisoned <= 1'b0;
      end
      if (cmd.count_zero) count <= '0;
      if (cmd.idx_clr) idx <= '0;
      else if (cmd.idx_inc) idx <= idx + CNTW'(1);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.out_box) begin
      res_kind    <= 1'b0;
      res_present <= box_valid;
      res_x       <= box_valid ? box.x[OUT_W-1:0] : '0;
      res_y       <= box_valid ? box.y[OUT_W-1:0] : '0;
      res_w       <= box_valid ? box.w[OUT_W-1:0] : '0;
      res_h       <= box_valid ? box.h[OUT_W-1:0] : '0;
      res_index   <= '0;
      res_last    <= cmd.out_last;
    end else if (cmd.out_rect) begin
      res_kind    <= 1'b1;
      res_present <= 1'b1;
      res_x       <= rd.x[OUT_W-1:0];
      res_y       <= rd.y[OUT_W-1:0];
      res_w       <= rd.w[OUT_W-1:0];
      res_h       <= rd.h[OUT_W-1:0];
      res_index   <= IDX_OUT_W'(idx);
      res_last    <= cmd.out_last;
    end
  end

  assign sts.op         = op;
  assign sts.area_ok    = (area.w > 0) && (area.h > 0);
  assign sts.box_valid  = box_valid;
  assign sts.poisoned   = poisoned;
  assign sts.keep       = keep_list;
  assign sts.list_empty = (count == '0);
  assign sts.full       = (count == CNTW'(RECT_SLOTS));
  assign sts.at_end     = (idx == count);
  assign sts.overlap    = (area.x < rx1) && (ax1 > rd.x) && (area.y < ry1) && (ay1 > rd.y);
  assign sts.clamp_ok   = (rd_clamped.w > 0) && (rd_clamped.h > 0);
  assign sts.last_rect  = ((idx + CNTW'(1)) == count);
  assign sts.out_last   = res_last;
endmodule

>>> rtl/dirty_rect_tracker.sv
// dirty_rect_tracker: top level, configuration registers and assertions.
// Depends on drt_pkg, drt_in_if, drt_out_if, drt_ctrl, drt_dp, drt_ram.
//
// Collects the damaged areas of one frame into a bounding box and a list of up to
// RECT_SLOTS rectangles held in a single-port-read RAM. Requests are handled one at a
// time. An add scans the stored rectangles in order unless the list is poisoned, merges
// into the first one it overlaps, else appends to the list or poisons a full list;
// every scan step waits on the registered RAM read. A finish clips the stored
// rectangles (skipped when the list is dropped or no box is held), then emits the box
// and each rectangle (read then present), and the result sink can stall each result.
// Configuration writes are taken at any time but must only land while the block is
// idle. No clearing pass is needed.
module dirty_rect_tracker import drt_pkg::*; #(
  parameter int RECT_SLOTS = RECT_SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  drt_in_if.sink               area_req,
  drt_out_if.source            result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CANVAS_W-1:0]  cfg_data
);
  drt_cmd_t cmd;
  drt_sts_t sts;

  logic [CANVAS_W-1:0] canvas_width, canvas_height;
  logic                keep_list;

  // Configuration registers; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= CANVAS_RESET;
      canvas_height <= CANVAS_RESET;
      keep_list     <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CANVAS_WIDTH:  canvas_width  <= cfg_data;
        CFG_CANVAS_HEIGHT: canvas_height <= cfg_data;
        CFG_KEEP_LIST:     keep_list     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  drt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (area_req.valid),
    .in_ready  (area_req.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  drt_dp #(.RECT_SLOTS(RECT_SLOTS)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .in_op         (area_req.op),
    .in_x          (area_req.area_x),
    .in_y          (area_req.area_y),
    .in_w          (area_req.area_w),
    .in_h          (area_req.area_h),
    .canvas_width  (canvas_width),
    .canvas_height (canvas_height),
    .keep_list     (keep_list),
    .res_kind      (result.kind),
    .res_present   (result.present),
    .res_x         (result.out_x),
    .res_y         (result.out_y),
    .res_w         (result.out_w),
    .res_h         (result.out_h),
    .res_index     (result.rect_index),
    .res_last      (result.last)
  );

  // One request in flight: no new request while a result is offered.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(result.valid && area_req.ready))
    else $error("request accepted while result pending");

  // Append only into a free slot.
  a_append_room: assert property (@(posedge clk) disable iff (rst)
    cmd.append_wr |-> !sts.full)
    else $error("append into full list");

  // After the final result the block is ready again.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.ready && result.last) |=> area_req.ready)
    else $error("not ready after last result");

  // A rectangle result is always flagged present.
  a_rect_kind: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.kind) |-> result.present)
    else $error("rectangle result without present");
endmodule

>>> test/dirty_rect_tracker_tb.sv
`timescale 1ns / 100ps
// dirty_rect_tracker_tb: self-checking bench for the dirty rectangle tracker.
// Depends on drt_pkg, drt_in_if, drt_out_if and dirty_rect_tracker.
module dirty_rect_tracker_tb;
  import drt_pkg::*;

  localparam int SLOTS       = RECT_SLOTS_DEF;
  localparam int STALL_LIMIT = 3000;  // cycles with no request moving on either side
  localparam int DRAIN_WAIT  = 80;    // longest add scan plus margin
  localparam int HOLD_CYCLES = 400;   // long receiver hold-off

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [1:0]  op;
    logic signed [15:0] x, y, w, h;
  } area_req_t;

  typedef struct {
    logic        kind;
    logic        present;
    logic [14:0] x, y, w, h;
    logic [3:0]  index;
    logic        last;
  } tile_t;

  typedef struct {
    area_req_t req;
    bit        typed;   // expected result typed in below
    tile_t     res;
  } stim_row_t;

  logic clk, rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CANVAS_W-1:0]  cfg_data;

  drt_in_if  area_req();
  drt_out_if result();

  dirty_rect_tracker dut (
    .clk(clk), .rst(rst), .area_req(area_req), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Tracker shadow: canvas settings, box and rectangle list, int arithmetic.
  // ---------------------------------------------------------------------------
  int  canvas_w, canvas_h;
  bit  list_keep;
  bit  box_on;
  int  box_l, box_t, box_w, box_h;
  int  rect_l[SLOTS], rect_top[SLOTS], rect_w[SLOTS], rect_h[SLOTS];
  int  rect_num;
  bit  rects_poisoned;

  tile_t expected_tiles[$];
  tile_t finish_tiles[$];
  int    mismatch_count;

  idle_mode_t idle_mode;
  bit         hold_armed;
  int         quiet_cycles;

  function automatic void wipe_tracker();
    box_on = 0;
    box_l = 0; box_t = 0; box_w = 0; box_h = 0;
    for (int i = 0; i < SLOTS; i++) begin
      rect_l[i] = 0; rect_top[i] = 0; rect_w[i] = 0; rect_h[i] = 0;
    end
    rect_num = 0;
    rects_poisoned = 0;
  endfunction

  // Left/top clip first, then right/bottom; true while the rectangle stays non-empty.
  function automatic bit clip_to_canvas(inout int x, inout int y, inout int w, inout int h);
    if (x < 0) begin w += x; x = 0; end
    if (y < 0) begin h += y; y = 0; end
    if (x + w > canvas_w) w = canvas_w - x;
    if (y + h > canvas_h) h = canvas_h - y;
    return (w > 0) && (h > 0);
  endfunction

  function automatic tile_t make_tile(bit kind, bit present, int x, int y, int w, int h,
                                      int index, bit last);
    tile_t t;
    t.kind = kind; t.present = present;
    t.x = x[14:0]; t.y = y[14:0]; t.w = w[14:0]; t.h = h[14:0];
    t.index = index[3:0]; t.last = last;
    return t;
  endfunction

  function automatic void grow_damage(int x, int y, int w, int h);
    int x1, y1, rx1, ry1, mx, my, mx1, my1;
    x1 = x + w;
    y1 = y + h;
    if (!box_on) begin
      box_l = x; box_t = y; box_w = w; box_h = h; box_on = 1;
    end else begin
      if (x < box_l) begin box_w += box_l - x; box_l = x; end
      if (y < box_t) begin box_h += box_t - y; box_t = y; end
      if (x1 > box_l + box_w) box_w = x1 - box_l;
      if (y1 > box_t + box_h) box_h = y1 - box_t;
    end
    if (rects_poisoned) return;
    // first overlapping rectangle swallows the area
    for (int i = 0; i < rect_num; i++) begin
      rx1 = rect_l[i] + rect_w[i];
      ry1 = rect_top[i] + rect_h[i];
      if (x < rx1 && x1 > rect_l[i] && y < ry1 && y1 > rect_top[i]) begin
        mx  = (x < rect_l[i]) ? x : rect_l[i];
        my  = (y < rect_top[i]) ? y : rect_top[i];
        mx1 = (x1 > rx1) ? x1 : rx1;
        my1 = (y1 > ry1) ? y1 : ry1;
        rect_l[i] = mx; rect_top[i] = my; rect_w[i] = mx1 - mx; rect_h[i] = my1 - my;
        return;
      end
    end
    if (rect_num >= SLOTS) begin
      rects_poisoned = 1;
      return;
    end
    rect_l[rect_num] = x; rect_top[rect_num] = y;
    rect_w[rect_num] = w; rect_h[rect_num] = h;
    rect_num++;
  endfunction

  // Finish: clip state in place, then emit the box and the surviving list.
  function automatic void close_frame();
    finish_tiles.delete();
    if (!box_on) begin
      finish_tiles.push_back(make_tile(0, 0, 0, 0, 0, 0, 0, 1));
      return;
    end
    if (!clip_to_canvas(box_l, box_t, box_w, box_h)) box_on = 0;
    if (box_on && box_w >= canvas_w && box_h >= canvas_h) box_on = 0;
    if (!box_on || rects_poisoned || rect_num == 0 || !list_keep) begin
      rect_num = 0;
      rects_poisoned = 0;
    end else begin
      for (int i = 0; i < rect_num; i++)
        if (!clip_to_canvas(rect_l[i], rect_top[i], rect_w[i], rect_h[i])) begin
          rect_num = 0;
          break;
        end
    end
    if (!box_on) begin
      finish_tiles.push_back(make_tile(0, 0, 0, 0, 0, 0, 0, 1));
      return;
    end
    finish_tiles.push_back(make_tile(0, 1, box_l, box_t, box_w, box_h, 0, rect_num == 0));
    for (int i = 0; i < rect_num; i++)
      finish_tiles.push_back(make_tile(1, 1, rect_l[i], rect_top[i], rect_w[i], rect_h[i],
                                       i, i + 1 == rect_num));
  endfunction

  // Applies one accepted request to the shadow; finish results land in finish_tiles.
  function automatic void track_request(area_req_t r);
    finish_tiles.delete();
    case (r.op)
      OP_CLEAR:  wipe_tracker();
      OP_ADD:    if (r.w > 0 && r.h > 0) grow_damage(int'(r.x), int'(r.y), int'(r.w),
                                                     int'(r.h));
      OP_FINISH: close_frame();
      default: ;  // unused op: no effect
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  task automatic send_request(area_req_t r);
    area_req.valid  <= 1'b1;
    area_req.op     <= r.op;
    area_req.area_x <= r.x;
    area_req.area_y <= r.y;
    area_req.area_w <= r.w;
    area_req.area_h <= r.h;
    do @(posedge clk); while (!area_req.ready);
    track_request(r);
    foreach (finish_tiles[i]) expected_tiles.push_back(finish_tiles[i]);
    // sender gaps
    if ((idle_mode == IDLE_SEND && $urandom_range(99) < 49) ||
        (idle_mode == IDLE_BOTH && $urandom_range(99) < 6)) begin
      area_req.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CANVAS_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_CANVAS_WIDTH:  canvas_w  = value & 16'h7FFF;
      CFG_CANVAS_HEIGHT: canvas_h  = value & 16'h7FFF;
      CFG_KEEP_LIST:     list_keep = value[0];
      default: ;
    endcase
  endtask

  // Drain outstanding results and let any trailing add scan finish.
  task automatic settle();
    area_req.valid <= 1'b0;
    while (expected_tiles.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic area_req_t mk_req(logic [1:0] op, int x, int y, int w, int h);
    area_req_t r;
    r.op = op; r.x = x[15:0]; r.y = y[15:0]; r.w = w[15:0]; r.h = h[15:0];
    return r;
  endfunction

  function automatic stim_row_t row(area_req_t r);
    stim_row_t s;
    s.req = r; s.typed = 0; s.res = make_tile(0, 0, 0, 0, 0, 0, 0, 0);
    return s;
  endfunction

  function automatic stim_row_t row_absent(area_req_t r);
    stim_row_t s;
    s.req = r; s.typed = 1; s.res = make_tile(0, 0, 0, 0, 0, 0, 0, 1);
    return s;
  endfunction

  // One frame of random content: normal damage, a list-filling burst, or noise.
  task automatic random_frame(inout int sent);
    int pick, n, span_w, span_h;
    area_req_t r;
    pick   = $urandom_range(99);
    span_w = (canvas_w > 0) ? canvas_w : 16;
    span_h = (canvas_h > 0) ? canvas_h : 16;
    if ($urandom_range(99) < 70) begin
      send_request(mk_req(OP_CLEAR, 0, 0, 0, 0)); sent++;
    end
    if (pick < 60) begin
      n = $urandom_range(1, 8);
      repeat (n) begin
        send_request(mk_req(OP_ADD, $urandom_range(span_w + 40) - 20,
                            $urandom_range(span_h + 40) - 20,
                            $urandom_range(1, span_w / 3 + 2),
                            $urandom_range(1, span_h / 3 + 2)));
        sent++;
      end
    end else if (pick < 78) begin
      // disjoint strips: fills the list, sometimes past its end
      n = $urandom_range(SLOTS - 2, SLOTS + 3);
      for (int k = 0; k < n; k++) begin
        send_request(mk_req(OP_ADD, k * (span_w / 20 + 2), $urandom_range(span_h / 2),
                            span_w / 20 + 1, $urandom_range(1, span_h / 2 + 1)));
        sent++;
      end
    end else begin
      n = $urandom_range(2, 6);
      repeat (n) begin
        r.op = 2'($urandom_range(3));
        r.x = 16'($urandom); r.y = 16'($urandom);
        r.w = 16'($urandom); r.h = 16'($urandom);
        send_request(r); sent++;
      end
    end
    send_request(mk_req(OP_FINISH, 0, 0, 0, 0)); sent++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready pattern, long hold-off, checking
  // ---------------------------------------------------------------------------
  int hold_left;

  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (result.valid && result.ready) begin
        if (expected_tiles.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected result kind=%0d x=%0d y=%0d w=%0d h=%0d idx=%0d",
                     $realtime, result.kind, result.out_x, result.out_y, result.out_w,
                     result.out_h, result.rect_index);
        end else begin
          tile_t e;
          e = expected_tiles.pop_front();
          if (result.kind !== e.kind || result.present !== e.present ||
              result.out_x !== e.x || result.out_y !== e.y || result.out_w !== e.w ||
              result.out_h !== e.h || result.rect_index !== e.index ||
              result.last !== e.last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"%0t: result mismatch exp kind=%0d pres=%0d x=%0d y=%0d w=%0d ",
                        "h=%0d idx=%0d last=%0d / got %0d %0d %0d %0d %0d %0d %0d %0d"},
                       $realtime, e.kind, e.present, e.x, e.y, e.w, e.h, e.index, e.last,
                       result.kind, result.present, result.out_x, result.out_y,
                       result.out_w, result.out_h, result.rect_index, result.last);
          end
        end
      end
      if (hold_armed && hold_left == 0) begin
        hold_armed = 0;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result.ready <= 1'b0;
      end else if (idle_mode == IDLE_RECV)
        result.ready <= ($urandom_range(99) >= 49);
      else if (idle_mode == IDLE_BOTH)
        result.ready <= ($urandom_range(99) >= 6);
      else
        result.ready <= 1'b1;
    end
  end

  // Watchdog: counts cycles in which no request moves on either channel.
  always @(posedge clk) begin
    if (rst || (area_req.valid && area_req.ready) || (result.valid && result.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("dirty_rect_tracker_tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  stim_row_t directed[$];
  int        sent;
  int        phase_w[6] = '{32767, 1, 0, 200, 640, 1024};
  int        phase_h[6] = '{32767, 1, 0, 150, 480, 1024};
  int        phase_k[6] = '{1, 1, 1, 0, 1, 1};
  idle_mode_t phase_idle[6] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_RECV,
                                IDLE_NONE};

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    area_req.valid = 1'b0; area_req.op = OP_CLEAR;
    area_req.area_x = '0; area_req.area_y = '0; area_req.area_w = '0; area_req.area_h = '0;
    idle_mode = IDLE_NONE;
    hold_armed = 0;
    mismatch_count = 0;
    quiet_cycles = 0;
    canvas_w = int'(CANVAS_RESET); canvas_h = int'(CANVAS_RESET); list_keep = 1;
    wipe_tracker();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows at reset settings.
    directed.push_back(row_absent(mk_req(OP_FINISH, 0, 0, 0, 0)));   // nothing tracked
    directed.push_back(row(mk_req(OP_ADD, 5, 5, 0, 7)));              // zero width ignored
    directed.push_back(row(mk_req(OP_ADD, 5, 5, 7, -32768)));         // negative height
    directed.push_back(row_absent(mk_req(OP_FINISH, 0, 0, 0, 0)));
    directed.push_back(row(mk_req(OP_ADD, 10, 20, 30, 40)));
    directed.push_back(row(mk_req(OP_ADD, 15, 25, 10, 10)));          // merges
    directed.push_back(row(mk_req(OP_ADD, 100, 100, 5, 5)));          // appends
    directed.push_back(row(mk_req(OP_FINISH, 0, 0, 0, 0)));
    directed.push_back(row(mk_req(OP_ADD, -32768, -32768, 32767, 32767))); // clips empty
    directed.push_back(row(mk_req(OP_FINISH, 0, 0, 0, 0)));           // list dropped
    directed.push_back(row(mk_req(OP_ADD, 32767, 32767, 32767, 32767)));
    directed.push_back(row(mk_req(OP_FINISH, 0, 0, 0, 0)));
    directed.push_back(row(mk_req(2'd3, -1, -1, -1, -1)));            // unused op
    directed.push_back(row(mk_req(OP_CLEAR, 0, 0, 0, 0)));
    directed.push_back(row(mk_req(OP_ADD, -4, -4, 1100, 1100)));      // covers canvas
    directed.push_back(row_absent(mk_req(OP_FINISH, 0, 0, 0, 0)));
    directed.push_back(row(mk_req(OP_CLEAR, 0, 0, 0, 0)));
    directed.push_back(row(mk_req(OP_ADD, 1000, 1000, 100, 100)));    // partly off canvas
    directed.push_back(row(mk_req(OP_ADD, 0, 0, 1, 1)));
    directed.push_back(row(mk_req(OP_FINISH, 0, 0, 0, 0)));
    directed.push_back(row(mk_req(OP_ADD, 2000, 0, 5, 5)));           // beyond right edge
    directed.push_back(row(mk_req(OP_FINISH, 0, 0, 0, 0)));

    foreach (directed[i]) begin
      send_request(directed[i].req);
      if (directed[i].typed) begin
        // typed result replaces the shadow's single result
        void'(expected_tiles.pop_back());
        expected_tiles.push_back(directed[i].res);
      end
    end
    sent = directed.size();
    settle();

    // Random phases, each under its own settings and idle pattern.
    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_CANVAS_WIDTH, phase_w[p]);
      write_reg(CFG_CANVAS_HEIGHT, phase_h[p]);
      write_reg(CFG_KEEP_LIST, phase_k[p]);
      idle_mode = phase_idle[p];
      // long receiver hold-off while requests keep coming
      if (p == 4) hold_armed = 1;
      while (sent < directed.size() + 24 * (p + 1)) random_frame(sent);
      settle();
    end

    if (mismatch_count == 0 && expected_tiles.size() == 0)
      $display("dirty_rect_tracker_tb: PASS");
    else
      $display("dirty_rect_tracker_tb: FAIL");
    $finish;
  end

endmodule
